// ===== rtl/core/mru_pkg.sv =====
// Shared types, codes and reset values of the message record unpacker.
package mru_pkg;

   localparam int DataWidth      = 8;
   localparam int ValueWidth     = 64;
   localparam int RecordWidth    = 16;
   localparam int RegWidth       = 32;
   localparam int CsrIndexWidth  = 2;

   // Parse phases.
   localparam logic [3:0] PH_COUNT   = 4'd0;
   localparam logic [3:0] PH_MAGIC   = 4'd1;
   localparam logic [3:0] PH_VERSION = 4'd2;
   localparam logic [3:0] PH_SEQ     = 4'd3;
   localparam logic [3:0] PH_TIME    = 4'd4;
   localparam logic [3:0] PH_EXPIRY  = 4'd5;
   localparam logic [3:0] PH_SLEN    = 4'd6;
   localparam logic [3:0] PH_SSTR    = 4'd7;
   localparam logic [3:0] PH_RLEN    = 4'd8;
   localparam logic [3:0] PH_RSTR    = 4'd9;
   localparam logic [3:0] PH_PLEN    = 4'd10;
   localparam logic [3:0] PH_PAY     = 4'd11;

   // Event kinds.
   localparam logic [3:0] EV_NONE      = 4'd0;
   localparam logic [3:0] EV_COUNT     = 4'd1;
   localparam logic [3:0] EV_VERSION   = 4'd2;
   localparam logic [3:0] EV_SEQ       = 4'd3;
   localparam logic [3:0] EV_TIMESTAMP = 4'd4;
   localparam logic [3:0] EV_EXPIRY    = 4'd5;
   localparam logic [3:0] EV_SENDER    = 4'd6;
   localparam logic [3:0] EV_RECIPIENT = 4'd7;
   localparam logic [3:0] EV_PAYLOAD   = 4'd8;
   localparam logic [3:0] EV_PAY_LEN   = 4'd9;

   // Error codes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
   localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
   localparam logic [2:0] ERR_TOO_MANY    = 3'd3;
   localparam logic [2:0] ERR_PAY_LARGE   = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

   // Register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_RECORD_MAGIC    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_RECORDS     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_PAYLOAD_LEN = 2'd2;

   // Register reset values.
   localparam logic [31:0] RESET_RECORD_MAGIC    = 32'd0;
   localparam logic [15:0] RESET_MAX_RECORDS     = 16'd1000;
   localparam logic [31:0] RESET_MAX_PAYLOAD_LEN = 32'd65536;

   // Accepted version numbers.
   localparam logic [7:0] VERSION_ONE = 8'd1;
   localparam logic [7:0] VERSION_TWO = 8'd2;

   typedef struct packed {
      logic [31:0] record_magic;
      logic [15:0] max_records;
      logic [31:0] max_payload_len;
   } cfg_type;

   typedef struct packed {
      logic [3:0]             event_kind;
      logic [ValueWidth-1:0]  field_value;
      logic [RecordWidth-1:0] record_number;
      logic                   record_end;
      logic                   stream_done;
      logic [2:0]             error_code;
   } result_type;

endpackage

// ===== rtl/core/mru_csr_regs.sv =====
// Configuration registers of the message record unpacker.
module mru_csr_regs
   import mru_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]      csr_write_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RECORD_MAGIC:    cfg_in.record_magic    = csr_write_data;
            CSR_MAX_RECORDS:     cfg_in.max_records     = csr_write_data[15:0];
            CSR_MAX_PAYLOAD_LEN: cfg_in.max_payload_len = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.record_magic    <= RESET_RECORD_MAGIC;
         cfg_ff.max_records     <= RESET_MAX_RECORDS;
         cfg_ff.max_payload_len <= RESET_MAX_PAYLOAD_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/mru_parser.sv =====
// Field parser: parse state registers and the per-byte next-state logic.
module mru_parser
   import mru_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [DataWidth-1:0] data_byte,
   input  logic                 last_byte,
   input  cfg_type              cfg,
   output result_type           result
);

   logic [3:0]             phase_ff, phase_in;
   logic [2:0]             fbc_ff, fbc_in;
   logic [ValueWidth-1:0]  shift_ff, shift_in;
   logic [RecordWidth-1:0] records_left_ff, records_left_in;
   logic [RecordWidth-1:0] current_record_ff, current_record_in;
   logic [31:0]            bytes_left_ff, bytes_left_in;
   logic                   finished_ff, finished_in;
   logic                   error_ff, error_in;

   logic [2:0]             count_inc;
   logic [ValueWidth-1:0]  shifted;
   logic [31:0]            bytes_dec;
   logic [RecordWidth-1:0] records_dec;
   logic                   rec_complete;

   assign count_inc   = fbc_ff + 3'd1;
   assign shifted     = {shift_ff[ValueWidth-DataWidth-1:0], data_byte};
   assign bytes_dec   = bytes_left_ff - 32'd1;
   assign records_dec = records_left_ff - 16'd1;

   always_comb begin
      phase_in          = phase_ff;
      fbc_in            = fbc_ff;
      shift_in          = shift_ff;
      records_left_in   = records_left_ff;
      current_record_in = current_record_ff;
      bytes_left_in     = bytes_left_ff;
      finished_in       = finished_ff;
      error_in          = error_ff;
      rec_complete      = 1'b0;

      result               = '0;
      result.record_number = current_record_ff;

      if (!finished_ff && !error_ff) begin
         unique case (phase_ff)
            PH_COUNT, PH_MAGIC: begin
               shift_in = shifted;
               fbc_in   = count_inc;
               if (count_inc == 3'd4) begin
                  fbc_in   = 3'd0;
                  shift_in = '0;
                  if (phase_ff == PH_MAGIC) begin
                     if (shifted[31:0] != cfg.record_magic) begin
                        error_in          = 1'b1;
                        result.error_code = ERR_BAD_MAGIC;
                     end else begin
                        phase_in = PH_VERSION;
                     end
                  end else if (shifted[31:0] == 32'd0) begin
                     result.event_kind  = EV_COUNT;
                     finished_in        = 1'b1;
                     result.stream_done = 1'b1;
                  end else if (shifted[31:0] > {16'd0, cfg.max_records}) begin
                     error_in          = 1'b1;
                     result.error_code = ERR_TOO_MANY;
                  end else begin
                     result.event_kind  = EV_COUNT;
                     result.field_value = {32'd0, shifted[31:0]};
                     records_left_in    = shifted[15:0];
                     phase_in           = PH_MAGIC;
                  end
               end
            end
            PH_VERSION: begin
               if (data_byte == VERSION_ONE || data_byte == VERSION_TWO) begin
                  result.event_kind  = EV_VERSION;
                  result.field_value = {56'd0, data_byte};
                  phase_in = (data_byte == VERSION_TWO) ? PH_SEQ : PH_TIME;
               end else begin
                  error_in          = 1'b1;
                  result.error_code = ERR_BAD_VERSION;
               end
            end
            PH_SEQ, PH_TIME, PH_EXPIRY: begin
               shift_in = shifted;
               fbc_in   = count_inc;
               // An eight-byte field completes when the three-bit count wraps.
               if (count_inc == 3'd0) begin
                  result.field_value = shifted;
                  shift_in           = '0;
                  phase_in           = phase_ff + 4'd1;
                  if (phase_ff == PH_SEQ) begin
                     result.event_kind = EV_SEQ;
                  end else if (phase_ff == PH_TIME) begin
                     result.event_kind = EV_TIMESTAMP;
                  end else begin
                     result.event_kind = EV_EXPIRY;
                  end
               end
            end
            PH_SLEN, PH_RLEN: begin
               shift_in = shifted;
               fbc_in   = count_inc;
               if (count_inc == 3'd2) begin
                  fbc_in        = 3'd0;
                  shift_in      = '0;
                  bytes_left_in = {16'd0, shifted[15:0]};
                  phase_in = (shifted[15:0] != 16'd0) ? phase_ff + 4'd1 : phase_ff + 4'd2;
               end
            end
            PH_SSTR, PH_RSTR: begin
               result.event_kind  = (phase_ff == PH_SSTR) ? EV_SENDER : EV_RECIPIENT;
               result.field_value = {56'd0, data_byte};
               bytes_left_in      = bytes_dec;
               if (bytes_dec == 32'd0) begin
                  phase_in = phase_ff + 4'd1;
               end
            end
            PH_PLEN: begin
               shift_in = shifted;
               fbc_in   = count_inc;
               if (count_inc == 3'd4) begin
                  fbc_in   = 3'd0;
                  shift_in = '0;
                  if (shifted[31:0] > cfg.max_payload_len) begin
                     error_in          = 1'b1;
                     result.error_code = ERR_PAY_LARGE;
                  end else begin
                     result.event_kind  = EV_PAY_LEN;
                     result.field_value = {32'd0, shifted[31:0]};
                     bytes_left_in      = shifted[31:0];
                     if (shifted[31:0] == 32'd0) begin
                        rec_complete = 1'b1;
                     end else begin
                        phase_in = PH_PAY;
                     end
                  end
               end
            end
            PH_PAY: begin
               result.event_kind  = EV_PAYLOAD;
               result.field_value = {56'd0, data_byte};
               bytes_left_in      = bytes_dec;
               if (bytes_dec == 32'd0) begin
                  rec_complete = 1'b1;
               end
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase

         if (rec_complete) begin
            result.record_end = 1'b1;
            records_left_in   = records_dec;
            current_record_in = current_record_ff + 16'd1;
            if (records_dec == 16'd0) begin
               finished_in        = 1'b1;
               result.stream_done = 1'b1;
            end else begin
               phase_in = PH_MAGIC;
            end
         end
      end

      // The last byte of a buffer reports truncation if records are still
      // owed, and always returns the parse state to its idle values.
      if (last_byte) begin
         if (!finished_in && !error_in && result.error_code == ERR_NONE) begin
            result.error_code = ERR_TRUNCATED;
         end
         phase_in          = PH_COUNT;
         fbc_in            = 3'd0;
         shift_in          = '0;
         records_left_in   = '0;
         current_record_in = '0;
         bytes_left_in     = '0;
         finished_in       = 1'b0;
         error_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_COUNT;
         fbc_ff            <= 3'd0;
         shift_ff          <= '0;
         records_left_ff   <= '0;
         current_record_ff <= '0;
         bytes_left_ff     <= '0;
         finished_ff       <= 1'b0;
         error_ff          <= 1'b0;
      end else if (fire) begin
         phase_ff          <= phase_in;
         fbc_ff            <= fbc_in;
         shift_ff          <= shift_in;
         records_left_ff   <= records_left_in;
         current_record_ff <= current_record_in;
         bytes_left_ff     <= bytes_left_in;
         finished_ff       <= finished_in;
         error_ff          <= error_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      fire && result.error_code != ERR_NONE && result.error_code != ERR_TRUNCATED
      |-> result.event_kind == EV_NONE && result.field_value == '0)
      else $error("error result carries an event");

   assert property (@(posedge clock) disable iff (reset)
      fire && result.record_end && !last_byte
      |=> current_record_ff == $past(current_record_ff) + 16'd1)
      else $error("record index did not advance on record end");

   assert property (@(posedge clock) disable iff (reset)
      fire && result.stream_done && !last_byte |=> finished_ff)
      else $error("stream done without finished state");

   assert property (@(posedge clock) disable iff (reset)
      fire && last_byte
      |=> phase_ff == PH_COUNT && !finished_ff && !error_ff && fbc_ff == 3'd0)
      else $error("parse state not rearmed after last byte");
`endif

endmodule

// ===== rtl/core/message_record_unpacker.sv =====
// Top level of the message record unpacker: request/response stages around the parser.
//
//   Channel  Ports            Handshake               Moves
//   request  req_*            req_valid / req_ready   one buffer byte and its last flag
//   response rsp_*            rsp_valid / rsp_ready   one event, record and error report
//   config   csr_*            csr_write_en            one register write, no wait
//
// Throughput is one request per cycle when the response side does not stall; each
// byte's parse is a single pass of combinational logic between the request register
// and the response register; each response is loaded there as its byte is passed on.
// Reset is synchronous and active high; it clears the parse state, both stage
// valid flags, and loads the register defaults.
// When the response side stalls, the request register still takes one more
// byte, and req_ready falls only once both stages are full.
//
// Every accepted request yields exactly one response. Parse state advances at
// the moment a byte moves from the request register into the response
// register, so a stall freezes both the state and the waiting response.
module message_record_unpacker
   import mru_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [DataWidth-1:0]     req_data_byte,
   input  logic                     req_last_byte,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               rsp_event_kind,
   output logic [ValueWidth-1:0]    rsp_field_value,
   output logic [RecordWidth-1:0]   rsp_record_number,
   output logic                     rsp_record_end,
   output logic                     rsp_stream_done,
   output logic [2:0]               rsp_error_code,

   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]      csr_write_data
);

   // Request stage.
   logic                 in_valid_ff, in_valid_in;
   logic [DataWidth-1:0] in_data_ff;
   logic                 in_last_ff;

   // Response stage.
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;

   cfg_type              cfg;
   result_type           result;
   logic                 advance;
   logic                 fire;
   logic                 take;

   // The response register can load when it is empty or being drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers hold their value until the stage is reloaded.
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   mru_csr_regs u_csr_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   mru_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_ff.event_kind;
   assign rsp_field_value   = out_ff.field_value;
   assign rsp_record_number = out_ff.record_number;
   assign rsp_record_end    = out_ff.record_end;
   assign rsp_stream_done   = out_ff.stream_done;
   assign rsp_error_code    = out_ff.error_code;

endmodule
